// ----- hdl/mpp_pkg.sv -----
// Package for the MQTT PUBLISH receive parser.
// Holds the transaction structs, the parser phase and result kind codes, and
// the protocol constants. No dependencies.
package mpp_pkg;

	localparam int LEN_BYTES_MAX = 4;   // remaining length bytes allowed
	localparam int LEN_GRP_W     = 7;   // value bits per length byte

	localparam logic [3:0] PKT_PUBLISH = 4'h3;
	localparam logic [1:0] ID_BYTES    = 2'd2;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_LEN     = 4'd1,
		PH_TLEN_HI = 4'd2,
		PH_TLEN_LO = 4'd3,
		PH_TOPIC   = 4'd4,
		PH_ID      = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_SKIP    = 4'd7,
		PH_HALT    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TOPIC   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} rx_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} res_item_t;

endpackage

// ----- hdl/mpp_parser.sv -----
// Byte-wise parser state machine: fixed header, remaining length, topic length
// check and section tracking. One byte is consumed per fire.
// Depends on mpp_pkg.
module mpp_parser #(
	parameter int MAX_LEN_BYTES = mpp_pkg::LEN_BYTES_MAX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  mpp_pkg::rx_item_t  item,
	output logic               res_valid,
	output mpp_pkg::res_item_t res
);
	import mpp_pkg::*;

	localparam int LenW = LEN_GRP_W * MAX_LEN_BYTES;
	localparam int CntW = $clog2(MAX_LEN_BYTES + 1);
	localparam int CmpW = (LenW > 17) ? LenW : 17;

	phase_t            phase_q, phase_d;
	logic [1:0]        qos_q, qos_d;
	logic              is_pub_q, is_pub_d;
	logic [LenW-1:0]   accum_q, accum_d;
	logic [CntW-1:0]   cnt_q, cnt_d;
	logic [LenW-1:0]   body_q, body_d;
	logic [7:0]        tlen_hi_q, tlen_hi_d;
	logic [15:0]       topic_q, topic_d;
	logic [1:0]        id_q, id_d;

	logic [7:0]        b;
	logic [LenW-1:0]   grp;
	logic [LenW-1:0]   accum_new;
	logic [CntW-1:0]   cnt_inc;
	logic              len_err;
	logic [LenW-1:0]   body_dec;
	logic              body_dec_zero;
	logic [15:0]       tlen;
	logic [1:0]        id_init;
	logic [16:0]       need;
	logic              short_pub;
	logic [15:0]       topic_dec;
	logic [1:0]        id_dec;

	function automatic phase_t next_section(input logic [15:0] t_left,
		input logic [1:0] i_left, input logic [LenW-1:0] b_left);
		phase_t ph;
		if (t_left != '0)
			ph = PH_TOPIC;
		else if (i_left != '0)
			ph = PH_ID;
		else if (b_left != '0)
			ph = PH_PAYLOAD;
		else
			ph = PH_HDR;
		return ph;
	endfunction

	assign b = item.rx_byte;

	// place this length byte's seven bits at its group; earlier groups never overlap
	always_comb begin
		grp = '0;
		for (int g = 0; g < MAX_LEN_BYTES; g++) begin
			if (cnt_q == CntW'(g))
				grp[g*LEN_GRP_W +: LEN_GRP_W] = b[LEN_GRP_W-1:0];
		end
	end

	assign accum_new     = accum_q | grp;
	assign cnt_inc       = cnt_q + CntW'(1);
	assign len_err       = b[7] && (cnt_inc >= CntW'(MAX_LEN_BYTES));
	assign body_dec      = body_q - LenW'(1);
	assign body_dec_zero = (body_dec == '0);
	assign tlen          = {tlen_hi_q, b};
	assign id_init       = (qos_q != 2'd0) ? ID_BYTES : 2'd0;
	assign need          = {1'b0, tlen} + {15'd0, id_init};
	assign short_pub     = CmpW'(body_dec) < CmpW'(need);
	assign topic_dec     = topic_q - 16'd1;
	assign id_dec        = id_q - 2'd1;

	// next state
	always_comb begin
		phase_d   = phase_q;
		qos_d     = qos_q;
		is_pub_d  = is_pub_q;
		accum_d   = accum_q;
		cnt_d     = cnt_q;
		body_d    = body_q;
		tlen_hi_d = tlen_hi_q;
		topic_d   = topic_q;
		id_d      = id_q;
		if (fire) begin
			if (item.restart) begin
				phase_d   = PH_HDR;
				qos_d     = '0;
				is_pub_d  = 1'b0;
				accum_d   = '0;
				cnt_d     = '0;
				body_d    = '0;
				tlen_hi_d = '0;
				topic_d   = '0;
				id_d      = '0;
			end else begin
				unique case (phase_q)
					PH_HDR: begin
						is_pub_d = (b[7:4] == PKT_PUBLISH);
						qos_d    = b[2:1];
						accum_d  = '0;
						cnt_d    = '0;
						phase_d  = PH_LEN;
					end
					PH_LEN: begin
						accum_d = accum_new;
						cnt_d   = cnt_inc;
						if (b[7]) begin
							if (len_err)
								phase_d = PH_HALT;
						end else begin
							body_d = accum_new;
							if (accum_new == '0)
								phase_d = PH_HDR;
							else if (!is_pub_q || accum_new < LenW'(2))
								phase_d = PH_SKIP;
							else
								phase_d = PH_TLEN_HI;
						end
					end
					PH_TLEN_HI: begin
						tlen_hi_d = b;
						body_d    = body_dec;
						phase_d   = PH_TLEN_LO;
					end
					PH_TLEN_LO: begin
						body_d = body_dec;
						if (short_pub) begin
							phase_d = body_dec_zero ? PH_HDR : PH_SKIP;
						end else begin
							topic_d = tlen;
							id_d    = id_init;
							phase_d = next_section(tlen, id_init, body_dec);
						end
					end
					PH_TOPIC: begin
						topic_d = topic_dec;
						body_d  = body_dec;
						phase_d = next_section(topic_dec, id_q, body_dec);
					end
					PH_ID: begin
						id_d    = id_dec;
						body_d  = body_dec;
						phase_d = next_section(topic_q, id_dec, body_dec);
					end
					PH_PAYLOAD: begin
						body_d  = body_dec;
						phase_d = next_section(topic_q, id_q, body_dec);
					end
					PH_SKIP: begin
						if (body_q != '0) begin
							body_d = body_dec;
							if (body_dec_zero)
								phase_d = PH_HDR;
						end else begin
							phase_d = PH_HDR;
						end
					end
					PH_HALT: phase_d = PH_HALT;
					default: phase_d = PH_HALT;
				endcase
			end
		end
	end

	// result for the byte being consumed
	always_comb begin
		res_valid = 1'b0;
		res.kind  = KIND_TOPIC;
		res.data  = '0;
		res.last  = 1'b0;
		if (fire && !item.restart) begin
			unique case (phase_q)
				PH_LEN: begin
					if (len_err) begin
						res_valid = 1'b1;
						res.kind  = KIND_ERROR;
					end
				end
				PH_TLEN_LO: begin
					if (!short_pub && body_dec_zero) begin
						res_valid = 1'b1;
						res.kind  = KIND_END;
						res.last  = 1'b1;
					end
				end
				PH_TOPIC: begin
					res_valid = 1'b1;
					res.kind  = KIND_TOPIC;
					res.data  = b;
					res.last  = body_dec_zero;
				end
				PH_ID: begin
					if (body_dec_zero) begin
						res_valid = 1'b1;
						res.kind  = KIND_END;
						res.last  = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					res_valid = 1'b1;
					res.kind  = KIND_PAYLOAD;
					res.data  = b;
					res.last  = body_dec_zero;
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			qos_q     <= '0;
			is_pub_q  <= 1'b0;
			accum_q   <= '0;
			cnt_q     <= '0;
			body_q    <= '0;
			tlen_hi_q <= '0;
			topic_q   <= '0;
			id_q      <= '0;
		end else begin
			phase_q   <= phase_d;
			qos_q     <= qos_d;
			is_pub_q  <= is_pub_d;
			accum_q   <= accum_d;
			cnt_q     <= cnt_d;
			body_q    <= body_d;
			tlen_hi_q <= tlen_hi_d;
			topic_q   <= topic_d;
			id_q      <= id_d;
		end
	end

endmodule

// ----- hdl/mpp_out_reg.sv -----
// Result register for the parser: holds one result transaction until the
// downstream side takes it.
// Depends on mpp_pkg.
module mpp_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               load_valid,
	input  mpp_pkg::res_item_t load_item,
	output logic               valid,
	input  logic               stall,
	output mpp_pkg::res_item_t item,
	output logic               busy
);
	import mpp_pkg::*;

	logic      valid_q;
	res_item_t item_q;

	// cannot take a new result while the held one is stalled
	assign busy  = valid_q && stall;
	assign valid = valid_q;
	assign item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid)
			item_q <= load_item;
	end

endmodule

// ----- hdl/mqtt_publish_rx_parser.sv -----
// MQTT 3.1.1 PUBLISH receive parser, top level.
// Each accepted byte passes through the input register, then the parser logic into the
// result register. Throughput: one byte per cycle while the result register is not
// stalled; a stalled result holds the byte in the input register and raises rx_stall.
// Reset: arst_n clears both registers' valid bits and returns the parser to
// awaiting a fixed header.
module mqtt_publish_rx_parser #(
	parameter int MAX_LEN_BYTES = mpp_pkg::LEN_BYTES_MAX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  mpp_pkg::rx_item_t  rx_item,
	output logic               res_valid,
	input  logic               res_stall,
	output mpp_pkg::res_item_t res_item
);
	import mpp_pkg::*;

	logic      valid_s1;
	rx_item_t  item_s1;
	logic      out_busy;
	logic      fire;
	logic      p_valid;
	res_item_t p_res;

	assign fire     = valid_s1 && !out_busy;
	assign rx_stall = valid_s1 && out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall)
			item_s1 <= rx_item;
	end

	mpp_parser #(
		.MAX_LEN_BYTES(MAX_LEN_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.res_valid(p_valid),
		.res      (p_res)
	);

	mpp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.load_valid(p_valid),
		.load_item (p_res),
		.valid     (res_valid),
		.stall     (res_stall),
		.item      (res_item),
		.busy      (out_busy)
	);

endmodule
